@@ design/bfcq_pkg.sv @@
// ----------------------------------------------------------------------------
// bfcq_pkg
// Shared types and constants of the bracket frame collector queue.
// ----------------------------------------------------------------------------
package bfcq_pkg;

    localparam logic [7:0] OPEN_MARK  = 8'h5B;
    localparam logic [7:0] CLOSE_MARK = 8'h5D;
    localparam int         DROP_W     = 32;

    // One input word after decoding by the front end.
    typedef struct packed {
        logic       is_pop;
        logic       is_open;
        logic       is_close;
        logic [7:0] data;
    } cmd_t;

    // One result word waiting in the output buffer.
    typedef struct packed {
        logic [7:0]        data;
        logic              last;
        logic              empty;
        logic [DROP_W-1:0] drops;
    } result_t;

endpackage

@@ design/bfcq_ram.sv @@
// ----------------------------------------------------------------------------
// bfcq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bfcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/bfcq_front.sv @@
// ----------------------------------------------------------------------------
// bfcq_front
// Input side: accepts words, decodes bracket marks and pops, and holds them
// in a two-entry command queue toward the back end.
// ----------------------------------------------------------------------------
module bfcq_front import bfcq_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       func,
    input  logic [7:0] rx_byte,
    output logic       cmd_valid,
    output cmd_t       cmd,
    input  logic       cmd_take
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       cmd_in;
    logic       push, pop;

    always_comb
    begin
        cmd_in.is_pop   = func;
        cmd_in.is_open  = !func && (rx_byte == OPEN_MARK);
        cmd_in.is_close = !func && (rx_byte == CLOSE_MARK);
        cmd_in.data     = rx_byte;
    end

    assign in_stall  = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = in_valid && !in_stall;
    assign pop       = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

@@ design/bfcq_back.sv @@
// ----------------------------------------------------------------------------
// bfcq_back
// Execution side: collects frame bytes straight into the free ring slot,
// queues finished frames, counts drops, and streams popped frames out of the
// frame store through a two-entry output buffer.
// ----------------------------------------------------------------------------
module bfcq_back import bfcq_pkg::*; #(
    parameter int FRAME_LEN   = 64,
    parameter int QUEUE_SLOTS = 4,
    parameter int LEN_W       = 6,
    parameter int SLOT_W      = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  cmd_t              cmd,
    output logic              cmd_take,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        frame_byte,
    output logic              frame_last,
    output logic              queue_empty,
    output logic [DROP_W-1:0] dropped_frames
);

    localparam int                ADDR_W    = SLOT_W + LEN_W;
    localparam int                RAM_DEPTH = 2 ** ADDR_W;
    localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(FRAME_LEN - 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(QUEUE_SLOTS - 1);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_STREAM = 1'b1;

    logic              state_reg, state_next;
    logic              collecting_reg, collecting_next;
    logic [LEN_W-1:0]  plen_reg, plen_next;
    logic [SLOT_W-1:0] wslot_reg, wslot_next;
    logic [SLOT_W-1:0] rslot_reg, rslot_next;
    logic [DROP_W-1:0] drop_reg, drop_next;
    logic [LEN_W-1:0]  slot_len_reg [QUEUE_SLOTS];
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic [LEN_W-1:0]  cur_len_reg, cur_len_next;

    logic              infl_valid_reg;
    logic              infl_last_reg;
    logic              infl_marker_reg;
    logic [DROP_W-1:0] infl_drop_reg;

    result_t           obuf_reg [2];
    logic              owr_ptr_reg, ord_ptr_reg;
    logic [1:0]        ocount_reg, ocount_next;

    logic [SLOT_W-1:0] wslot_inc, rslot_inc;
    logic [LEN_W-1:0]  idx_inc;
    logic              ring_empty, out_pop, issue_ok;
    logic              issue, issue_last, issue_marker;
    logic              slot_len_we;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_rdata;
    result_t           obuf_in, obuf_head;

    bfcq_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.data),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign wslot_inc  = (wslot_reg == SLOT_LAST) ? '0 : wslot_reg + 1'b1;
    assign rslot_inc  = (rslot_reg == SLOT_LAST) ? '0 : rslot_reg + 1'b1;
    assign idx_inc    = idx_reg + 1'b1;
    assign ring_empty = (rslot_reg == wslot_reg);
    assign out_pop    = out_valid && !out_stall;
    // A read is started only when the output buffer is sure to have room
    // for its data once the frame store returns it.
    assign issue_ok   = ({1'b0, ocount_reg} + {2'b00, infl_valid_reg})
                        < (3'd2 + {2'b00, out_pop});
    assign ram_waddr  = {wslot_reg, plen_reg};
    assign ram_raddr  = {rslot_reg, idx_reg};

    always_comb
    begin
        state_next      = state_reg;
        collecting_next = collecting_reg;
        plen_next       = plen_reg;
        wslot_next      = wslot_reg;
        rslot_next      = rslot_reg;
        drop_next       = drop_reg;
        idx_next        = idx_reg;
        cur_len_next    = cur_len_reg;
        cmd_take        = 1'b0;
        ram_we          = 1'b0;
        slot_len_we     = 1'b0;
        issue           = 1'b0;
        issue_last      = 1'b0;
        issue_marker    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.is_pop)
                    begin
                        if (ring_empty)
                        begin
                            if (issue_ok)
                            begin
                                issue        = 1'b1;
                                issue_last   = 1'b1;
                                issue_marker = 1'b1;
                                cmd_take     = 1'b1;
                            end
                        end
                        else
                        begin
                            cmd_take     = 1'b1;
                            state_next   = ST_STREAM;
                            idx_next     = '0;
                            cur_len_next = slot_len_reg[rslot_reg];
                        end
                    end
                    else
                    begin
                        cmd_take = 1'b1;
                        if (cmd.is_open)
                        begin
                            collecting_next = 1'b1;
                            plen_next       = '0;
                        end
                        else if (collecting_reg)
                        begin
                            if (cmd.is_close)
                            begin
                                if (plen_reg != '0)
                                begin
                                    if (wslot_inc != rslot_reg)
                                    begin
                                        slot_len_we = 1'b1;
                                        wslot_next  = wslot_inc;
                                    end
                                    else
                                    begin
                                        drop_next = drop_reg + 32'd1;
                                    end
                                end
                                collecting_next = 1'b0;
                                plen_next       = '0;
                            end
                            else if (plen_reg < LEN_MAX)
                            begin
                                // The slot at the write pointer is always free,
                                // so the partial frame is built in place there.
                                ram_we    = 1'b1;
                                plen_next = plen_reg + 1'b1;
                            end
                            else
                            begin
                                collecting_next = 1'b0;
                                plen_next       = '0;
                                drop_next       = drop_reg + 32'd1;
                            end
                        end
                    end
                end
            end
            ST_STREAM:
            begin
                if (issue_ok)
                begin
                    issue      = 1'b1;
                    issue_last = (idx_inc == cur_len_reg);
                    idx_next   = idx_inc;
                    if (issue_last)
                    begin
                        rslot_next = rslot_inc;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            collecting_reg <= 1'b0;
            plen_reg       <= '0;
            wslot_reg      <= '0;
            rslot_reg      <= '0;
            drop_reg       <= '0;
            idx_reg        <= '0;
            cur_len_reg    <= '0;
            infl_valid_reg <= 1'b0;
            owr_ptr_reg    <= 1'b0;
            ord_ptr_reg    <= 1'b0;
            ocount_reg     <= 2'd0;
        end
        else
        begin
            state_reg      <= state_next;
            collecting_reg <= collecting_next;
            plen_reg       <= plen_next;
            wslot_reg      <= wslot_next;
            rslot_reg      <= rslot_next;
            drop_reg       <= drop_next;
            idx_reg        <= idx_next;
            cur_len_reg    <= cur_len_next;
            infl_valid_reg <= issue;
            owr_ptr_reg    <= infl_valid_reg ? !owr_ptr_reg : owr_ptr_reg;
            ord_ptr_reg    <= out_pop ? !ord_ptr_reg : ord_ptr_reg;
            ocount_reg     <= ocount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_len_we)
        begin
            slot_len_reg[wslot_reg] <= plen_reg;
        end
        if (issue)
        begin
            infl_last_reg   <= issue_last;
            infl_marker_reg <= issue_marker;
            infl_drop_reg   <= drop_reg;
        end
        if (infl_valid_reg)
        begin
            obuf_reg[owr_ptr_reg] <= obuf_in;
        end
    end

    always_comb
    begin
        obuf_in.data  = infl_marker_reg ? 8'h00 : ram_rdata;
        obuf_in.last  = infl_last_reg;
        obuf_in.empty = infl_marker_reg;
        obuf_in.drops = infl_drop_reg;
        ocount_next   = ocount_reg + {1'b0, infl_valid_reg} - {1'b0, out_pop};
    end

    assign obuf_head      = obuf_reg[ord_ptr_reg];
    assign out_valid      = (ocount_reg != 2'd0);
    assign frame_byte     = obuf_head.data;
    assign frame_last     = obuf_head.last;
    assign queue_empty    = obuf_head.empty;
    assign dropped_frames = obuf_head.drops;

endmodule

@@ design/bracket_frame_collector_queue.sv @@
// ----------------------------------------------------------------------------
// bracket_frame_collector_queue
// Receives bytes, collects '[' ... ']' frames into a ring of frame slots and
// returns the oldest frame byte by byte on request.
// ----------------------------------------------------------------------------
// A received byte is taken by the back end and produces no result. A pop of
// a frame of N bytes produces N result words at one word per cycle while the
// output is not stalled, paced by the single read port of the frame store;
// the first word passes through the stream state, the registered read of the
// frame store and the output buffer before it is presented. A pop on an empty
// ring produces one empty marker (byte 0, last and queue_empty set), presented
// through the output buffer. Items are executed strictly in order, so words
// arriving during a pop wait in the two-entry input queue. At most
// QUEUE_SLOTS-1 frames of up to FRAME_LEN-1 bytes are held; a frame that finds
// the ring full or grows too long is dropped, counted in dropped_frames, which
// every result word carries. The frame store needs no clearing after reset.
// ----------------------------------------------------------------------------
module bracket_frame_collector_queue import bfcq_pkg::*; #(
    parameter int FRAME_LEN   = 64,
    parameter int QUEUE_SLOTS = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              func,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        frame_byte,
    output logic              frame_last,
    output logic              queue_empty,
    output logic [DROP_W-1:0] dropped_frames
);

    localparam int LEN_W  = $clog2(FRAME_LEN);
    localparam int SLOT_W = $clog2(QUEUE_SLOTS);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_take;

    bfcq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .rx_byte   (rx_byte),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    bfcq_back #(
        .FRAME_LEN   (FRAME_LEN),
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .LEN_W       (LEN_W),
        .SLOT_W      (SLOT_W)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_take       (cmd_take),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frame_byte     (frame_byte),
        .frame_last     (frame_last),
        .queue_empty    (queue_empty),
        .dropped_frames (dropped_frames)
    );

endmodule

@@ design/bfcq_checker.sv @@
// ----------------------------------------------------------------------------
// bfcq_checker
// Port-level checks of the bracket frame collector queue, bound to the top.
// ----------------------------------------------------------------------------
module bfcq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  frame_byte,
    input logic        frame_last,
    input logic        queue_empty,
    input logic [31:0] dropped_frames
);

    logic        mid_frame_reg;
    logic [31:0] drop_hold_reg;
    logic        out_take;

    assign out_take = out_valid && !out_stall;

    // Tracks whether the last word taken left a frame unfinished.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_frame_reg <= 1'b0;
            drop_hold_reg <= 32'd0;
        end
        else if (out_take)
        begin
            mid_frame_reg <= !frame_last;
            drop_hold_reg <= dropped_frames;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_byte)
            && $stable(frame_last) && $stable(queue_empty) && $stable(dropped_frames))
        else $error("result word changed while stalled");

    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && queue_empty |-> frame_last && (frame_byte == 8'h00))
        else $error("empty marker is not a zero last word");

    a_frame_drop_steady: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mid_frame_reg |-> !queue_empty && (dropped_frames == drop_hold_reg))
        else $error("drop count or marker changed inside a frame");

    a_input_stall_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !in_stall |=> !(in_stall && $past(!in_valid)))
        else $error("input stalled without a new word");

endmodule

bind bracket_frame_collector_queue bfcq_checker u_bfcq_checker (.*);

@@ dv/frame_queue_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_queue_checker
// Watches both channels of the bracket frame collector queue, predicts the
// result words from the accepted input words and compares them in order.
// ----------------------------------------------------------------------------
module frame_queue_checker import bfcq_pkg::*; #(
    parameter int   FRAME_LEN   = 64,
    parameter int   QUEUE_SLOTS = 4,
    parameter logic POP_FUNC    = 1'b1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic              func,
    input  logic [7:0]        rx_byte,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [7:0]        frame_byte,
    input  logic              frame_last,
    input  logic              queue_empty,
    input  logic [DROP_W-1:0] dropped_frames,
    output int                mismatches,
    output int                pending_words
);

    // Predicted state of the collector and the frame ring.
    logic              in_frame;
    logic [6:0]        part_len;
    logic [7:0]        part_buf [FRAME_LEN];
    logic [7:0]        slot_bytes [QUEUE_SLOTS][FRAME_LEN];
    logic [6:0]        slot_len [QUEUE_SLOTS];
    int                wr_slot;
    int                rd_slot;
    logic [DROP_W-1:0] drop_count;

    result_t expected_words [$];

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns mismatch: %s", $time, what);
    endtask

    task automatic absorb_rx_byte(input logic [7:0] b);
        int nxt;
        if (b == OPEN_MARK) begin
            in_frame = 1'b1;
            part_len = '0;
        end else if (in_frame) begin
            if (b == CLOSE_MARK) begin
                // An empty frame closes without queuing or counting anything.
                if (part_len != 0) begin
                    nxt = (wr_slot + 1) % QUEUE_SLOTS;
                    if (nxt != rd_slot) begin
                        for (int k = 0; k < part_len; k++)
                            slot_bytes[wr_slot][k] = part_buf[k];
                        slot_len[wr_slot] = part_len;
                        wr_slot = nxt;
                    end else begin
                        drop_count++;
                    end
                end
                in_frame = 1'b0;
                part_len = '0;
            end else if (part_len < FRAME_LEN - 1) begin
                part_buf[part_len] = b;
                part_len++;
            end else begin
                // Overlong frame: abandoned until the next open bracket.
                in_frame = 1'b0;
                part_len = '0;
                drop_count++;
            end
        end
    endtask

    task automatic pop_oldest_frame();
        result_t w;
        if (rd_slot == wr_slot) begin
            w.data  = 8'h00;
            w.last  = 1'b1;
            w.empty = 1'b1;
            w.drops = drop_count;
            expected_words.push_back(w);
        end else begin
            for (int k = 0; k < slot_len[rd_slot]; k++) begin
                w.data  = slot_bytes[rd_slot][k];
                w.last  = (k + 1 == slot_len[rd_slot]);
                w.empty = 1'b0;
                w.drops = drop_count;
                expected_words.push_back(w);
            end
            rd_slot = (rd_slot + 1) % QUEUE_SLOTS;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        result_t want;
        if (!rst_n) begin
            in_frame   = 1'b0;
            part_len   = '0;
            wr_slot    = 0;
            rd_slot    = 0;
            drop_count = '0;
            expected_words.delete();
            pending_words <= 0;
        end else begin
            if (in_valid && !in_stall) begin
                if (func == POP_FUNC)
                    pop_oldest_frame();
                else
                    absorb_rx_byte(rx_byte);
            end
            if (out_valid && !out_stall) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected word, frame_byte %02h",
                                              frame_byte));
                end else begin
                    want = expected_words.pop_front();
                    if (frame_byte !== want.data)
                        report_mismatch($sformatf("frame_byte %02h, expected %02h",
                                                  frame_byte, want.data));
                    if (frame_last !== want.last)
                        report_mismatch($sformatf("frame_last %b, expected %b",
                                                  frame_last, want.last));
                    if (queue_empty !== want.empty)
                        report_mismatch($sformatf("queue_empty %b, expected %b",
                                                  queue_empty, want.empty));
                    if (dropped_frames !== want.drops)
                        report_mismatch($sformatf("dropped_frames %0d, expected %0d",
                                                  dropped_frames, want.drops));
                end
            end
            pending_words <= expected_words.size();
        end
    end

endmodule

@@ dv/tb_bracket_frame_collector_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bracket_frame_collector_queue
// Drives bytes and pop requests into the frame collector queue with random
// gaps and output stalls; a checker beside the block predicts every word.
// ----------------------------------------------------------------------------
module tb_bracket_frame_collector_queue;
    import bfcq_pkg::*;

    localparam int   FRAME_LEN       = 64;
    localparam int   QUEUE_SLOTS     = 4;
    localparam logic FUNC_RX         = 1'b0;
    localparam logic FUNC_POP        = 1'b1;
    localparam int   HOLDOFF_CYCLES  = 300;
    localparam int   DRAIN_CYCLES    = 16;
    localparam int   PHASE_WORDS     = 110;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid;
    logic              in_stall;
    logic              func;
    logic [7:0]        rx_byte;
    logic              out_valid;
    logic              out_stall;
    logic [7:0]        frame_byte;
    logic              frame_last;
    logic              queue_empty;
    logic [DROP_W-1:0] dropped_frames;

    int mismatches;
    int pending_words;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int words_sent    = 0;
    int noise_words   = 0;
    bit hold_request  = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    bracket_frame_collector_queue #(
        .FRAME_LEN   (FRAME_LEN),
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frame_byte     (frame_byte),
        .frame_last     (frame_last),
        .queue_empty    (queue_empty),
        .dropped_frames (dropped_frames)
    );

    frame_queue_checker #(
        .FRAME_LEN   (FRAME_LEN),
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .POP_FUNC    (FUNC_POP)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frame_byte     (frame_byte),
        .frame_last     (frame_last),
        .queue_empty    (queue_empty),
        .dropped_frames (dropped_frames),
        .mismatches     (mismatches),
        .pending_words  (pending_words)
    );

    // Offers one word and returns once it has been accepted.
    task automatic send_word(input logic f, input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    task automatic send_pop();
        send_word(FUNC_POP, 8'($urandom_range(0, 255)));
    endtask

    // A payload byte that is not a bracket, except now and then.
    function automatic logic [7:0] payload_byte();
        logic [7:0] b;
        if ($urandom_range(0, 99) < 3)
            return 8'($urandom_range(0, 255));
        do
            b = 8'($urandom_range(0, 255));
        while (b == OPEN_MARK || b == CLOSE_MARK);
        return b;
    endfunction

    task automatic send_frame(input int len);
        send_word(FUNC_RX, OPEN_MARK);
        repeat (len) send_word(FUNC_RX, payload_byte());
        send_word(FUNC_RX, CLOSE_MARK);
    endtask

    task automatic drain_expected();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0) @(posedge clk);
    endtask

    task automatic run_random(input int n_words);
        int goal;
        int pick;
        int len;
        goal = words_sent - noise_words + n_words;
        while (words_sent - noise_words < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 28) begin
                repeat ($urandom_range(1, 3)) send_pop();
            end else if (pick < 36) begin
                send_word(FUNC_RX, 8'($urandom_range(0, 255)));
                noise_words++;
            end else if (pick < 42) begin
                // The frame is left open; later words extend it, finish it or restart it.
                send_word(FUNC_RX, OPEN_MARK);
                repeat ($urandom_range(0, 4)) send_word(FUNC_RX, payload_byte());
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    len = 0;
                else if (pick < 75)
                    len = $urandom_range(1, 6);
                else if (pick < 87)
                    len = $urandom_range(7, 20);
                else if (pick < 94)
                    len = FRAME_LEN - 1;
                else
                    len = $urandom_range(FRAME_LEN, FRAME_LEN + 2);
                send_frame(len);
            end
        end
    endtask

    // Receiver side: random stalls, or one long hold-off when requested.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end else begin
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    initial
    begin
        #3000000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        in_valid = 1'b0;
        func     = FUNC_RX;
        rx_byte  = 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        send_word(FUNC_POP, 8'hFF);
        send_word(FUNC_RX, CLOSE_MARK);
        send_word(FUNC_RX, 8'hA5);
        send_word(FUNC_RX, OPEN_MARK);
        send_word(FUNC_RX, CLOSE_MARK);
        send_word(FUNC_RX, OPEN_MARK);
        send_word(FUNC_RX, 8'h00);
        send_word(FUNC_RX, 8'hFF);
        send_word(FUNC_RX, CLOSE_MARK);
        // A second open bracket discards the partial frame.
        send_word(FUNC_RX, OPEN_MARK);
        send_word(FUNC_RX, 8'h41);
        send_word(FUNC_RX, OPEN_MARK);
        send_word(FUNC_RX, 8'h42);
        send_word(FUNC_RX, CLOSE_MARK);
        // The third queued frame fills the ring, so the fourth is dropped.
        send_word(FUNC_RX, OPEN_MARK);
        send_word(FUNC_RX, 8'h01);
        send_word(FUNC_RX, CLOSE_MARK);
        send_word(FUNC_RX, OPEN_MARK);
        send_word(FUNC_RX, 8'h02);
        send_word(FUNC_RX, CLOSE_MARK);
        repeat (4) send_pop();
        drain_expected();

        send_idle_pct = 31;
        recv_idle_pct = 72;
        run_random(PHASE_WORDS);
        drain_expected();

        send_idle_pct = 72;
        recv_idle_pct = 31;
        run_random(PHASE_WORDS);
        drain_expected();

        // Queue a few frames, then keep popping while the receiver holds off
        // so that the block backs up and stalls its input.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) send_frame($urandom_range(1, 6));
        hold_request = 1'b1;
        repeat (8) send_pop();
        run_random(PHASE_WORDS);
        drain_expected();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
